FILE: hdl/priority_nearest_unit_dispatch_core_defines.svh
// assertion macros for the dispatch core checker
`ifndef PRIORITY_NEAREST_UNIT_DISPATCH_CORE_DEFINES_SVH
`define PRIORITY_NEAREST_UNIT_DISPATCH_CORE_DEFINES_SVH

// property checked on every clock edge outside reset
`define PNUD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every clock edge, reset included
`define PNUD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/pnud_pkg.sv
// ---------------------------------------------------------------------------
// pnud_pkg
// shared types and codes of the dispatch core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pnud_pkg;

   localparam int FIELD_COORD_BITS = 17;
   localparam int DIST_BITS        = 35;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_PUSH     = 2'd1,
      OP_DISPATCH = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED = 3'd0,
      ST_ASSIGNED = 3'd1,
      ST_NO_UNIT  = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]                  req_type;
      logic [FIELD_COORD_BITS-1:0] pos_x;
      logic [FIELD_COORD_BITS-1:0] pos_y;
      logic [7:0]                  severity;
      logic [31:0]                 time_stamp;
      logic [15:0]                 request_tag;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [15:0]          out_tag;
      logic [7:0]           unit_index;
      logic [DIST_BITS-1:0] distance_sq;
      logic [31:0]          out_time;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_QREAD,
      S_QSCAN,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_UREAD,
      S_USCAN,
      S_MARK,
      S_DONE
   } state_type;

   // sequencer controls to the distance unit
   typedef struct packed {
      logic start;
      logic valid;
      logic last;
   } dist_ctrl_type;

endpackage
`default_nettype wire

FILE: hdl/pnud_ram.sv
// ---------------------------------------------------------------------------
// pnud_ram
// generic single-port-write, single-read ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pnud_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: hdl/pnud_dist.sv
// ---------------------------------------------------------------------------
// pnud_dist
// shared squared-distance unit with running minimum
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pnud_dist #(
   parameter int COORD_BITS = 17,
   parameter int IDX_BITS   = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pnud_pkg::dist_ctrl_type       ctrl,
   input  wire logic [COORD_BITS-1:0]         ref_x,
   input  wire logic [COORD_BITS-1:0]         ref_y,
   input  wire logic [COORD_BITS-1:0]         unit_x,
   input  wire logic [COORD_BITS-1:0]         unit_y,
   input  wire logic                          unit_free,
   input  wire logic [IDX_BITS-1:0]           unit_idx,
   output logic                               found,
   output logic [2*COORD_BITS:0]              best_dist,
   output logic [IDX_BITS-1:0]                best_idx,
   output logic                               done
);
   import pnud_pkg::*;
   localparam int DW = 2*COORD_BITS + 1;

   logic [COORD_BITS-1:0] dx_in, dy_in;
   logic [COORD_BITS-1:0] dx_ff, dy_ff;
   logic                  s1_valid_ff, s1_free_ff, s1_last_ff;
   logic [IDX_BITS-1:0]   s1_idx_ff;
   logic [2*COORD_BITS-1:0] px_ff, py_ff;
   logic                  s2_valid_ff, s2_free_ff, s2_last_ff;
   logic [IDX_BITS-1:0]   s2_idx_ff;
   logic [DW-1:0]         sum;
   logic                  found_ff;
   logic [DW-1:0]         best_ff;
   logic [IDX_BITS-1:0]   bidx_ff;
   logic                  done_ff;

   assign dx_in = (ref_x > unit_x) ? ref_x - unit_x : unit_x - ref_x;
   assign dy_in = (ref_y > unit_y) ? ref_y - unit_y : unit_y - ref_y;
   assign sum   = {1'b0, px_ff} + {1'b0, py_ff};

   always_ff @(posedge clock) begin
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      s1_free_ff <= unit_free;
      s1_idx_ff <= unit_idx;
      px_ff     <= dx_ff * dx_ff;
      py_ff     <= dy_ff * dy_ff;
      s2_free_ff <= s1_free_ff;
      s2_idx_ff <= s1_idx_ff;
      if (reset || ctrl.start) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         s2_last_ff  <= 1'b0;
         found_ff    <= 1'b0;
         done_ff     <= 1'b0;
         best_ff     <= '0;
         bidx_ff     <= '0;
      end else begin
         s1_valid_ff <= ctrl.valid;
         s1_last_ff  <= ctrl.valid && ctrl.last;
         s2_valid_ff <= s1_valid_ff;
         s2_last_ff  <= s1_last_ff;
         done_ff     <= s2_last_ff;
         if (s2_valid_ff && s2_free_ff && (!found_ff || sum < best_ff)) begin
            found_ff <= 1'b1;
            best_ff  <= sum;
            bidx_ff  <= s2_idx_ff;
         end
      end
   end

   assign found     = found_ff;
   assign best_dist = best_ff;
   assign best_idx  = bidx_ff;
   assign done      = done_ff;
endmodule
`default_nettype wire

FILE: hdl/priority_nearest_unit_dispatch_core.sv
// ---------------------------------------------------------------------------
// priority_nearest_unit_dispatch_core
// request queue with priority pop and nearest free unit assignment
// ---------------------------------------------------------------------------
// channel  dir  handshake        payload
// req      in   req_valid/stall  req_payload_type
// rsp      out  rsp_valid/stall  rsp_payload_type
//
// load, push, clear: straight from idle to the done state
// dispatch: queue scan (n requests), shift out of the popped slot (a read and
//   a write state per moved entry), unit scan (one unit per cycle plus pipeline),
//   mark, done; the pace is set by the single queue and unit ram ports
// reset: synchronous, clears counts and control; rams need no clearing
// the result register holds while rsp_stall is high; no new transfer meanwhile
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module priority_nearest_unit_dispatch_core #(
   parameter int MAX_UNITS    = 256,
   parameter int MAX_REQUESTS = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire pnud_pkg::req_payload_type  req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output pnud_pkg::rsp_payload_type       rsp_payload
);
   import pnud_pkg::*;

   localparam int COORD_BITS = FIELD_COORD_BITS;
   localparam int UA = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
   localparam int UC = $clog2(MAX_UNITS + 1);
   localparam int QA = $clog2(MAX_REQUESTS);
   localparam int QC = $clog2(MAX_REQUESTS + 1);
   localparam int UW = 2*COORD_BITS + 1;        // x, y, free
   localparam int KW = 40;                      // severity, stamp
   localparam int PW = 2*COORD_BITS + 16;       // x, y, tag
   localparam int QW = KW + PW;
   localparam int DW = 2*COORD_BITS + 1;

   state_type state_ff, state_in;

   // latched item
   req_payload_type item_ff;
   logic [UC-1:0] ucount_ff;
   logic [QC-1:0] qcount_ff;
   logic [QA:0]   qi_ff;          // queue walk pointer
   logic [UC:0]   ui_ff;          // unit walk pointer
   logic [QA-1:0] top_ff;
   logic [KW-1:0] top_key_ff;
   logic [PW-1:0] top_pay_ff;
   logic          rd_valid_ff;    // queue read data is valid
   logic [QA-1:0] rd_idx_ff;      // queue slot whose data is on q_rdata
   rsp_payload_type rsp_ff, rsp_in;
   logic          rsp_valid_ff;
   logic          dispatched_ff, d_found_ff;

   // rams
   logic          u_we;
   logic [UA-1:0] u_waddr, u_raddr;
   logic [UW-1:0] u_wdata, u_rdata;
   logic          q_we;
   logic [QA-1:0] q_waddr, q_raddr;
   logic [QW-1:0] q_wdata, q_rdata;

   pnud_ram #(.WIDTH(UW), .DEPTH(1 << UA)) u_ram (
      .clock(clock), .wr_en(u_we), .wr_addr(u_waddr), .wr_data(u_wdata),
      .rd_addr(u_raddr), .rd_data(u_rdata));

   pnud_ram #(.WIDTH(QW), .DEPTH(1 << QA)) q_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata));

   // distance unit
   dist_ctrl_type dctrl;
   logic          d_found, d_done;
   logic [DW-1:0] d_best;
   logic [UA-1:0] d_bidx;
   logic [UA-1:0] s_idx_ff;       // index of unit whose data is on u_rdata
   logic          s_valid_ff, s_last_ff;

   pnud_dist #(.COORD_BITS(COORD_BITS), .IDX_BITS(UA)) u_dist (
      .clock(clock), .reset(reset), .ctrl(dctrl),
      .ref_x(top_pay_ff[PW-1 -: COORD_BITS]),
      .ref_y(top_pay_ff[PW-1-COORD_BITS -: COORD_BITS]),
      .unit_x(u_rdata[UW-1 -: COORD_BITS]),
      .unit_y(u_rdata[UW-1-COORD_BITS -: COORD_BITS]),
      .unit_free(u_rdata[0]), .unit_idx(s_idx_ff),
      .found(d_found), .best_dist(d_best), .best_idx(d_bidx), .done(d_done));

   logic accept;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;

   // rank compare: read entry beats current top (only strictly)
   logic beats;
   assign beats = (q_rdata[QW-1 -: 8] != top_key_ff[KW-1 -: 8]) ?
                  (q_rdata[QW-1 -: 8] > top_key_ff[KW-1 -: 8]) :
                  (q_rdata[QW-9 -: 32] < top_key_ff[31:0]);

   // first entry always taken, later ones only when strictly ahead
   logic          take;
   logic [QA-1:0] top_next;
   assign take     = rd_valid_ff && ((rd_idx_ff == '0) || beats);
   assign top_next = take ? rd_idx_ff : top_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (op_type'(req_payload.req_type) == OP_DISPATCH) state_in = S_QREAD;
               else state_in = S_DONE;
            end
         end
         S_QREAD: begin
            if (qcount_ff == '0) state_in = S_DONE;
            else state_in = S_QSCAN;
         end
         S_QSCAN: begin
            if (rd_valid_ff && (QC'(rd_idx_ff) + QC'(1) == qcount_ff))
               state_in = S_SHIFT_RD;
         end
         S_SHIFT_RD: begin
            if (QC'(qi_ff) + QC'(1) >= qcount_ff) state_in = S_UREAD;
            else state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         S_UREAD: begin
            if (ucount_ff == '0) state_in = S_MARK;
            else state_in = S_USCAN;
         end
         S_USCAN: if (d_done) state_in = S_MARK;
         S_MARK:  state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // ram addressing and control outputs
   always_comb begin
      u_we    = 1'b0;
      u_waddr = ucount_ff[UA-1:0];
      u_wdata = {item_ff.pos_x[COORD_BITS-1:0], item_ff.pos_y[COORD_BITS-1:0], 1'b1};
      u_raddr = ui_ff[UA-1:0];
      q_we    = 1'b0;
      q_waddr = qcount_ff[QA-1:0];
      q_wdata = {item_ff.severity, item_ff.time_stamp,
                 item_ff.pos_x[COORD_BITS-1:0], item_ff.pos_y[COORD_BITS-1:0],
                 item_ff.request_tag};
      q_raddr = qi_ff[QA-1:0];
      dctrl   = '0;
      case (state_ff)
         S_DONE: begin
            if (op_type'(item_ff.req_type) == OP_LOAD && UC'(MAX_UNITS) > ucount_ff)
               u_we = 1'b1;
            if (op_type'(item_ff.req_type) == OP_PUSH && QC'(MAX_REQUESTS) > qcount_ff)
               q_we = 1'b1;
            // chosen unit was read back during mark: rewrite it busy
            if (op_type'(item_ff.req_type) == OP_DISPATCH && dispatched_ff && d_found_ff) begin
               u_we    = 1'b1;
               u_waddr = d_bidx;
               u_wdata = {u_rdata[UW-1:1], 1'b0};
            end
         end
         S_SHIFT_RD: q_raddr = QA'(qi_ff + 1'b1);
         S_SHIFT_WR: begin
            q_we    = 1'b1;
            q_waddr = qi_ff[QA-1:0];
            q_wdata = q_rdata;
         end
         S_UREAD: dctrl.start = 1'b1;
         S_USCAN: begin
            dctrl.valid = s_valid_ff;
            dctrl.last  = s_last_ff;
         end
         S_MARK: u_raddr = d_bidx;
         default: ;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ucount_ff    <= '0;
         qcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DONE) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (state_ff == S_DONE) begin
            case (op_type'(item_ff.req_type))
               OP_LOAD: if (UC'(MAX_UNITS) > ucount_ff) ucount_ff <= ucount_ff + 1'b1;
               OP_PUSH: if (QC'(MAX_REQUESTS) > qcount_ff) qcount_ff <= qcount_ff + 1'b1;
               OP_CLEAR: begin
                  ucount_ff <= '0;
                  qcount_ff <= '0;
               end
               default: ;
            endcase
         end
         if (state_ff == S_SHIFT_RD && state_in == S_UREAD) qcount_ff <= qcount_ff - 1'b1;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) item_ff <= req_payload;
      case (state_ff)
         S_QREAD: begin
            qi_ff       <= '0;
            rd_valid_ff <= 1'b0;
            top_ff      <= '0;
         end
         S_QSCAN: begin
            if (state_in == S_SHIFT_RD) begin
               qi_ff       <= {1'b0, top_next};
               rd_valid_ff <= 1'b0;
            end else if (QC'(qi_ff) < qcount_ff) begin
               qi_ff       <= qi_ff + 1'b1;
               rd_idx_ff   <= qi_ff[QA-1:0];
               rd_valid_ff <= 1'b1;
            end else begin
               rd_valid_ff <= 1'b0;
            end
            if (take) begin
               top_ff     <= rd_idx_ff;
               top_key_ff <= q_rdata[QW-1 -: KW];
               top_pay_ff <= q_rdata[PW-1:0];
            end
         end
         S_SHIFT_WR: qi_ff <= qi_ff + 1'b1;
         S_UREAD: begin
            ui_ff      <= '0;
            s_valid_ff <= 1'b0;
            s_last_ff  <= 1'b0;
         end
         S_USCAN: begin
            if (UC'(ui_ff) < ucount_ff) begin
               ui_ff      <= ui_ff + 1'b1;
               s_idx_ff   <= ui_ff[UA-1:0];
               s_valid_ff <= 1'b1;
               s_last_ff  <= (UC'(ui_ff) + UC'(1) == ucount_ff);
            end else begin
               s_valid_ff <= 1'b0;
               s_last_ff  <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   // dispatch outcome flags
   always_ff @(posedge clock) begin
      if (state_ff == S_QREAD) begin
         dispatched_ff <= (qcount_ff != '0);
         d_found_ff    <= 1'b0;
      end
      if (state_ff == S_MARK) d_found_ff <= d_found;
   end

   // result word
   always_comb begin
      rsp_in        = '0;
      rsp_in.status = ST_ACCEPTED;
      case (op_type'(item_ff.req_type))
         OP_LOAD: if (!(UC'(MAX_UNITS) > ucount_ff)) rsp_in.status = ST_FULL;
         OP_PUSH: if (!(QC'(MAX_REQUESTS) > qcount_ff)) rsp_in.status = ST_FULL;
         OP_DISPATCH: begin
            if (!dispatched_ff) rsp_in.status = ST_EMPTY;
            else begin
               rsp_in.out_tag  = top_pay_ff[15:0];
               rsp_in.out_time = top_key_ff[31:0];
               if (d_found_ff) begin
                  rsp_in.status      = ST_ASSIGNED;
                  rsp_in.unit_index  = 8'(d_bidx);
                  rsp_in.distance_sq = DIST_BITS'(d_best);
               end else rsp_in.status = ST_NO_UNIT;
            end
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire

FILE: hdl/pnud_checker.sv
// ---------------------------------------------------------------------------
// pnud_checker
// port-level checks of the dispatch core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "priority_nearest_unit_dispatch_core_defines.svh"
module pnud_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire pnud_pkg::rsp_payload_type rsp_payload
);
   import pnud_pkg::*;

   `PNUD_ASSERT(a_busy_while_rsp, rsp_valid |-> req_stall, "input taken while result waits")
   `PNUD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "result changed while stalled")
   `PNUD_ASSERT(a_stat_range, rsp_valid |-> rsp_payload.status <= 3'(ST_FULL), "status out of range")
   `PNUD_ASSERT(a_no_unit_zero, rsp_valid && rsp_payload.status != 3'(ST_ASSIGNED) |-> rsp_payload.distance_sq == '0, "distance without assignment")
   `PNUD_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "result after reset")
endmodule

bind priority_nearest_unit_dispatch_core pnud_checker u_pnud_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload));
`default_nettype wire

FILE: sim/tb_priority_nearest_unit_dispatch_core.sv
// ---------------------------------------------------------------------------
// tb_priority_nearest_unit_dispatch_core
// self-checking bench for the dispatch core: directed table plus random
// load/push/dispatch/clear traffic, every response checked against a local
// predictor of the unit table and request queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_priority_nearest_unit_dispatch_core;
   import pnud_pkg::*;

   localparam int N_UNITS  = 256;
   localparam int N_REQS   = 1024;
   localparam int N_RANDOM = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   priority_nearest_unit_dispatch_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // predictor state: unit table and request queue in insertion order
   logic [16:0] unit_x [N_UNITS];
   logic [16:0] unit_y [N_UNITS];
   logic        unit_free [N_UNITS];
   int          units_loaded;
   req_payload_type pending_reqs [$];

   rsp_payload_type awaited_rsps [$];
   int error_count = 0;
   int rsp_count = 0;
   int assigned_count = 0;
   int full_count = 0;
   bit hold_off = 1'b0;   // long receiver stall in progress

   function automatic logic [34:0] sq_dist(logic [16:0] a, logic [16:0] b);
      logic [34:0] d;
      d = (a > b) ? 35'(a - b) : 35'(b - a);
      return d * d;
   endfunction

   // model one transfer and return the expected response
   function automatic rsp_payload_type predict_dispatch(req_payload_type p);
      rsp_payload_type r;
      int top;
      bit found;
      logic [34:0] best, d;
      r = '0;
      r.status = ST_ACCEPTED;
      case (op_type'(p.req_type))
         OP_LOAD: begin
            if (units_loaded >= N_UNITS) r.status = ST_FULL;
            else begin
               unit_x[units_loaded] = p.pos_x;
               unit_y[units_loaded] = p.pos_y;
               unit_free[units_loaded] = 1'b1;
               units_loaded++;
            end
         end
         OP_PUSH: begin
            if (pending_reqs.size() >= N_REQS) r.status = ST_FULL;
            else pending_reqs.insert(pending_reqs.size(), p);
         end
         OP_DISPATCH: begin
            if (pending_reqs.size() == 0) r.status = ST_EMPTY;
            else begin
               top = 0;
               // highest severity, then oldest stamp, then earliest insertion
               for (int i = 1; i < pending_reqs.size(); i++)
                  if (pending_reqs[i].severity != pending_reqs[top].severity ?
                      pending_reqs[i].severity > pending_reqs[top].severity :
                      pending_reqs[i].time_stamp < pending_reqs[top].time_stamp)
                     top = i;
               r.out_tag = pending_reqs[top].request_tag;
               r.out_time = pending_reqs[top].time_stamp;
               found = 1'b0;
               best = '0;
               for (int i = 0; i < units_loaded; i++) begin
                  if (unit_free[i]) begin
                     d = sq_dist(pending_reqs[top].pos_x, unit_x[i]) +
                         sq_dist(pending_reqs[top].pos_y, unit_y[i]);
                     if (!found || d < best) begin
                        found = 1'b1;
                        best = d;
                        r.unit_index = 8'(i);
                     end
                  end
               end
               if (found) begin
                  unit_free[r.unit_index] = 1'b0;
                  r.status = ST_ASSIGNED;
                  r.distance_sq = best;
               end else begin
                  r.status = ST_NO_UNIT;
               end
               pending_reqs.delete(top);
            end
         end
         default: begin
            units_loaded = 0;
            pending_reqs.delete();
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on response %0d: %s got %0h expected %0h", rsp_count, what, got, want);
      error_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsps.size() == 0) begin
            report_mismatch("unexpected transfer", 64'(rsp_payload.status), 64'd0);
         end else begin
            want = awaited_rsps.pop_front();
            if (rsp_payload.status != want.status)
               report_mismatch("status", 64'(rsp_payload.status), 64'(want.status));
            if (rsp_payload.out_tag != want.out_tag)
               report_mismatch("out_tag", 64'(rsp_payload.out_tag), 64'(want.out_tag));
            if (rsp_payload.unit_index != want.unit_index)
               report_mismatch("unit_index", 64'(rsp_payload.unit_index),
                               64'(want.unit_index));
            if (rsp_payload.distance_sq != want.distance_sq)
               report_mismatch("distance_sq", 64'(rsp_payload.distance_sq),
                               64'(want.distance_sq));
            if (rsp_payload.out_time != want.out_time)
               report_mismatch("out_time", 64'(rsp_payload.out_time), 64'(want.out_time));
            if (want.status == ST_ASSIGNED) assigned_count++;
            if (want.status == ST_FULL) full_count++;
         end
         rsp_count++;
      end
   end

   // receiver stall: mostly short gaps, a few long ones, long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // send one item: optional gap, then hold valid until the transfer
   task automatic send_item(req_payload_type p, bit gaps);
      int n;
      if (gaps && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_rsps.insert(awaited_rsps.size(), predict_dispatch(p));
   endtask

   function automatic req_payload_type make_item(op_type op, int x, int y, int sev,
                                                 logic [31:0] ts, int tag);
      req_payload_type p;
      p.req_type = op;
      p.pos_x = 17'(x);
      p.pos_y = 17'(y);
      p.severity = 8'(sev);
      p.time_stamp = ts;
      p.request_tag = 16'(tag);
      return p;
   endfunction

   // random coordinate: half clustered, else zero, maximum or uniform
   function automatic int rand_coord();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 17'h1FFFF;
         2: return $urandom_range(0, 17'h1FFFF);
         default: return $urandom_range(1000, 1063);
      endcase
   endfunction

   typedef struct {
      req_payload_type item;
      bit              fixed;   // expected response typed in below
      rsp_payload_type rsp;
   } directed_row_type;

   directed_row_type directed_rows [$];

   task automatic add_row(req_payload_type p, bit fixed, status_type st);
      directed_row_type row;
      row.item = p;
      row.fixed = fixed;
      row.rsp = '0;
      row.rsp.status = st;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   initial begin
      rsp_payload_type model_rsp;
      req_payload_type p;
      op_type op;
      int mode;

      units_loaded = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty queue, no unit, extremes, tie-breaks, clear
      add_row(make_item(OP_DISPATCH, 0, 0, 0, 0, 0), 1, ST_EMPTY);
      add_row(make_item(OP_PUSH, 5, 5, 9, 32'd7, 16'hFFFF), 1, ST_ACCEPTED);
      add_row(make_item(OP_DISPATCH, 0, 0, 0, 0, 0), 0, ST_NO_UNIT);
      add_row(make_item(OP_LOAD, 0, 0, 0, 0, 0), 1, ST_ACCEPTED);
      add_row(make_item(OP_LOAD, 17'h1FFFF, 17'h1FFFF, 0, 0, 0), 1, ST_ACCEPTED);
      add_row(make_item(OP_LOAD, 0, 0, 0, 0, 0), 1, ST_ACCEPTED);
      add_row(make_item(OP_PUSH, 17'h1FFFF, 0, 255, 32'hFFFFFFFF, 1), 1, ST_ACCEPTED);
      add_row(make_item(OP_PUSH, 0, 0, 255, 32'hFFFFFFFF, 2), 1, ST_ACCEPTED);
      add_row(make_item(OP_PUSH, 17'h1FFFF, 17'h1FFFF, 0, 0, 3), 1, ST_ACCEPTED);
      add_row(make_item(OP_PUSH, 0, 17'h1FFFF, 255, 0, 4), 1, ST_ACCEPTED);
      add_row(make_item(OP_DISPATCH, 0, 0, 0, 0, 0), 0, ST_ASSIGNED);
      add_row(make_item(OP_DISPATCH, 0, 0, 0, 0, 0), 0, ST_ASSIGNED);
      add_row(make_item(OP_DISPATCH, 0, 0, 0, 0, 0), 0, ST_ASSIGNED);
      add_row(make_item(OP_DISPATCH, 0, 0, 0, 0, 0), 0, ST_NO_UNIT);
      add_row(make_item(OP_DISPATCH, 0, 0, 0, 0, 0), 0, ST_EMPTY);
      add_row(make_item(OP_DISPATCH, 0, 0, 0, 0, 0), 1, ST_EMPTY);
      add_row(make_item(OP_CLEAR, 17'h1FFFF, 17'h1FFFF, 255, 32'hFFFFFFFF, 16'hFFFF), 1,
              ST_ACCEPTED);
      add_row(make_item(OP_DISPATCH, 0, 0, 0, 0, 0), 1, ST_EMPTY);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, 1'b1);
         if (directed_rows[i].fixed) begin
            model_rsp = awaited_rsps[$];
            if (model_rsp != directed_rows[i].rsp)
               report_mismatch("directed row", 64'(model_rsp.status),
                               64'(directed_rows[i].rsp.status));
         end
      end

      // fill both tables to overflow, with the receiver held off long enough
      // that the core backs up and stalls its input
      hold_off = 1'b1;
      for (int i = 0; i < N_UNITS + 2; i++)
         send_item(make_item(OP_LOAD, rand_coord(), rand_coord(), 0, 0, 0), 1'b0);
      for (int i = 0; i < N_REQS + 2; i++)
         send_item(make_item(OP_PUSH, rand_coord(), rand_coord(), $urandom_range(0, 3),
                             $urandom_range(0, 7), $urandom), 1'b0);
      for (int i = 0; i < 20; i++)
         send_item(make_item(OP_DISPATCH, 0, 0, 0, 0, 0), 1'b1);
      send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0), 1'b1);

      // random: short sessions of loads, pushes and dispatches, small tables
      for (int i = 0; i < N_RANDOM; i++) begin
         mode = $urandom_range(0, 99);
         if (mode < 2) op = OP_CLEAR;
         else if (mode < 22) op = OP_LOAD;
         else if (mode < 62) op = OP_PUSH;
         else op = OP_DISPATCH;
         p.req_type = op;
         p.pos_x = 17'(rand_coord());
         p.pos_y = 17'(rand_coord());
         p.severity = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
         p.time_stamp = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 15);
         p.request_tag = 16'($urandom);
         send_item(p, 1'b1);
      end
      req_valid <= 1'b0;

      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);

      $display("covered %0d responses, %0d assignments, %0d full-table rejections",
               rsp_count, assigned_count, full_count);
      $display("directed extremes, tie-breaks, overflow with back-pressure, random traffic");
      if (error_count == 0 && awaited_rsps.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #250ms;
      $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire
